>>> src/dbs_pkg.sv
// Package for the dual bounded stack: widths, action and status codes,
// shared structs and the capacity function. No dependencies.
`default_nettype none

package dbs_pkg;

    localparam int ENTRY_W     = 32;
    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int PTR_W       = ADDR_W + 1;
    localparam int LIMIT_W     = 9;
    localparam int INDEX_W     = 8;
    localparam int COUNT_W     = 9;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

    typedef enum logic [2:0] {
        ACT_PUSH_PARAM    = 3'd0,
        ACT_POP_PARAM     = 3'd1,
        ACT_READ_PARAM    = 3'd2,
        ACT_RELEASE_PARAM = 3'd3,
        ACT_PUSH_OP       = 3'd4,
        ACT_POP_OP        = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic {
        REG_PARAM_LIMIT = 1'b0,
        REG_OP_LIMIT    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        status_t            status;
        logic [ENTRY_W-1:0] value;
    } stk_res_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] param_limit;
        logic [LIMIT_W-1:0] op_limit;
    } cfg_t;

    // Largest depth a stack may reach under the given limit.
    function automatic logic [PTR_W-1:0] capacity(input logic [LIMIT_W-1:0] limit);
        logic [LIMIT_W-1:0] eff;
        eff = (limit > LIMIT_W'(STACK_DEPTH)) ? LIMIT_W'(STACK_DEPTH) : limit;
        if (eff == '0)
        begin
            return '0;
        end
        return PTR_W'(eff - 1'b1);
    endfunction

endpackage

`default_nettype wire

>>> src/dbs_cfg.sv
// Configuration registers of the dual bounded stack behind an APB-style port.
// Depends on dbs_pkg.
`default_nettype none

module dbs_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [dbs_pkg::APB_AW-1:0] paddr,
    input  wire logic [dbs_pkg::APB_DW-1:0] pwdata,
    output logic      [dbs_pkg::APB_DW-1:0] prdata,
    output logic                           pready,
    output dbs_pkg::cfg_t                  cfg
);
    import dbs_pkg::*;

    logic [LIMIT_W-1:0] param_limit_reg;
    logic [LIMIT_W-1:0] op_limit_reg;
    logic               wr_en;
    reg_idx_t           sel;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign sel    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            param_limit_reg <= LIMIT_RESET;
            op_limit_reg    <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_PARAM_LIMIT: param_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_OP_LIMIT:    op_limit_reg    <= pwdata[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_PARAM_LIMIT: prdata = APB_DW'(param_limit_reg);
            REG_OP_LIMIT:    prdata = APB_DW'(op_limit_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.param_limit = param_limit_reg;
    assign cfg.op_limit    = op_limit_reg;

endmodule

`default_nettype wire

>>> src/dbs_param_stack.sv
// Parameter stack: pointer, bounds checks, entry memory and indexed read.
// Depends on dbs_pkg.
`default_nettype none

module dbs_param_stack (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  dbs_pkg::action_t                 action,
    input  wire logic [dbs_pkg::ENTRY_W-1:0] push_value,
    input  wire logic [dbs_pkg::INDEX_W-1:0] index,
    input  wire logic [dbs_pkg::COUNT_W-1:0] count,
    input  wire logic [dbs_pkg::LIMIT_W-1:0] limit,
    output dbs_pkg::stk_res_t                res,
    output logic      [dbs_pkg::PTR_W-1:0]   depth
);
    import dbs_pkg::*;

    logic [ENTRY_W-1:0] mem [STACK_DEPTH];

    logic [PTR_W-1:0]   top_reg;
    logic [PTR_W-1:0]   top_next;
    status_t            status_reg;
    status_t            status_next;
    logic               rd_en_reg;
    logic               rd_en_next;
    logic [ENTRY_W-1:0] rdata_reg;
    logic               wr_en;
    logic [ADDR_W-1:0]  rd_addr;

    always_comb
    begin
        top_next    = top_reg;
        status_next = ST_OK;
        rd_en_next  = 1'b0;
        wr_en       = 1'b0;
        rd_addr     = ADDR_W'(top_reg - 1'b1);
        if (accept)
        begin
            case (action)
                ACT_PUSH_PARAM:
                begin
                    if (top_reg >= capacity(limit))
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        top_next = top_reg + 1'b1;
                    end
                end
                ACT_POP_PARAM:
                begin
                    if (top_reg == '0)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        top_next   = top_reg - 1'b1;
                        rd_en_next = 1'b1;
                    end
                end
                ACT_READ_PARAM:
                begin
                    rd_addr = ADDR_W'(index);
                    if (PTR_W'(index) >= top_reg)
                    begin
                        status_next = ST_BAD_INDEX;
                    end
                    else
                    begin
                        rd_en_next = 1'b1;
                    end
                end
                ACT_RELEASE_PARAM:
                begin
                    if (PTR_W'(count) > top_reg)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        top_next = top_reg - PTR_W'(count);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= '0;
            status_reg <= ST_OK;
            rd_en_reg  <= 1'b0;
        end
        else
        begin
            top_reg    <= top_next;
            status_reg <= status_next;
            rd_en_reg  <= rd_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[top_reg[ADDR_W-1:0]] <= push_value;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign res.status = status_reg;
    assign res.value  = rd_en_reg ? rdata_reg : '0;
    assign depth      = top_reg;

endmodule

`default_nettype wire

>>> src/dbs_op_stack.sv
// Operator stack: pointer, bounds checks, entry memory and top-of-stack peek.
// Depends on dbs_pkg.
`default_nettype none

module dbs_op_stack (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  dbs_pkg::action_t                 action,
    input  wire logic [dbs_pkg::ENTRY_W-1:0] push_value,
    input  wire logic [dbs_pkg::LIMIT_W-1:0] limit,
    output dbs_pkg::stk_res_t                res,
    output logic      [dbs_pkg::PTR_W-1:0]   depth,
    output logic      [dbs_pkg::ENTRY_W-1:0] top_value,
    output logic                             top_valid
);
    import dbs_pkg::*;

    logic [ENTRY_W-1:0] mem [STACK_DEPTH];

    logic [PTR_W-1:0]   top_reg;
    logic [PTR_W-1:0]   top_next;
    status_t            status_reg;
    status_t            status_next;
    logic               rd_en_reg;
    logic               rd_en_next;
    logic               byp_reg;
    logic [ENTRY_W-1:0] byp_val_reg;
    logic [ENTRY_W-1:0] rdata_a_reg;
    logic [ENTRY_W-1:0] rdata_b_reg;
    logic               wr_en;
    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  addr_b;

    always_comb
    begin
        top_next    = top_reg;
        status_next = ST_OK;
        rd_en_next  = 1'b0;
        wr_en       = 1'b0;
        if (accept)
        begin
            case (action)
                ACT_PUSH_OP:
                begin
                    if (top_reg >= capacity(limit))
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        top_next = top_reg + 1'b1;
                    end
                end
                ACT_POP_OP:
                begin
                    if (top_reg == '0)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        top_next   = top_reg - 1'b1;
                        rd_en_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign addr_a = ADDR_W'(top_reg - 1'b1);
    assign addr_b = ADDR_W'(top_next - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg    <= '0;
            status_reg <= ST_OK;
            rd_en_reg  <= 1'b0;
            byp_reg    <= 1'b0;
        end
        else
        begin
            top_reg    <= top_next;
            status_reg <= status_next;
            rd_en_reg  <= rd_en_next;
            byp_reg    <= wr_en;
        end
    end

    // A pushed entry becomes the new top in the same transfer, so it is
    // taken from the bypass register rather than from the memory.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[top_reg[ADDR_W-1:0]] <= push_value;
        end
        byp_val_reg <= push_value;
        rdata_a_reg <= mem[addr_a];
        rdata_b_reg <= mem[addr_b];
    end

    assign res.status = status_reg;
    assign res.value  = rd_en_reg ? rdata_a_reg : '0;
    assign depth      = top_reg;
    assign top_valid  = (top_reg != '0);
    assign top_value  = !top_valid ? '0 : (byp_reg ? byp_val_reg : rdata_b_reg);

endmodule

`default_nettype wire

>>> src/dual_bounded_stack.sv
// Top level of the dual bounded stack: configuration port, both stacks and
// the result strobe. Depends on dbs_pkg, dbs_cfg, dbs_param_stack and dbs_op_stack.
// The result of an action appears in the cycle after its start transfer.
// Throughput: one action per cycle; busy stays low, set by one read per memory port.
// Reset clears both stack pointers and sets both limits to 256; entries are not cleared.
// Results are strobed by done for one cycle and the receiver cannot stall them.
`default_nettype none

module dual_bounded_stack (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [2:0]                  action,
    input  wire logic [dbs_pkg::ENTRY_W-1:0] push_value,
    input  wire logic [dbs_pkg::INDEX_W-1:0] index,
    input  wire logic [dbs_pkg::COUNT_W-1:0] count,
    output logic                             done,
    output logic      [dbs_pkg::ENTRY_W-1:0] read_value,
    output logic      [dbs_pkg::ENTRY_W-1:0] op_top_value,
    output logic                             op_top_valid,
    output logic      [dbs_pkg::PTR_W-1:0]   param_depth,
    output logic      [dbs_pkg::PTR_W-1:0]   op_depth,
    output logic      [1:0]                  status,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dbs_pkg::APB_AW-1:0]  paddr,
    input  wire logic [dbs_pkg::APB_DW-1:0]  pwdata,
    output logic      [dbs_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import dbs_pkg::*;

    cfg_t     cfg;
    stk_res_t param_res;
    stk_res_t op_res;
    action_t  act;
    logic     accept;
    logic     done_reg;

    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign act    = action_t'(action);

    dbs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dbs_param_stack u_param (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (act),
        .push_value (push_value),
        .index      (index),
        .count      (count),
        .limit      (cfg.param_limit),
        .res        (param_res),
        .depth      (param_depth)
    );

    dbs_op_stack u_op (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (act),
        .push_value (push_value),
        .limit      (cfg.op_limit),
        .res        (op_res),
        .depth      (op_depth),
        .top_value  (op_top_value),
        .top_valid  (op_top_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    // Only one stack acts per transfer, so the other contributes zeros.
    assign done       = done_reg;
    assign read_value = param_res.value | op_res.value;
    assign status     = 2'(param_res.status) | 2'(op_res.status);

endmodule

`default_nettype wire

>>> tb/sv/dual_bounded_stack_test.sv
// Self-checking testbench for dual_bounded_stack: drives stack actions and APB limit writes,
// predicts every result and compares it field by field with the result strobe.
// Depends on dbs_pkg and dual_bounded_stack.
module dual_bounded_stack_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dbs_pkg::*;

    typedef struct {
        logic [2:0]         action;
        logic [ENTRY_W-1:0] push_value;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
    } stack_cmd_t;

    typedef struct {
        logic [ENTRY_W-1:0] read_value;
        logic [ENTRY_W-1:0] op_top_value;
        logic               op_top_valid;
        logic [PTR_W-1:0]   param_depth;
        logic [PTR_W-1:0]   op_depth;
        status_t            status;
    } stack_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [2:0] cmd_action = '0;
    logic [ENTRY_W-1:0] cmd_push_value = '0;
    logic [INDEX_W-1:0] cmd_index = '0;
    logic [COUNT_W-1:0] cmd_count = '0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;

    wire logic busy;
    wire logic done;
    wire logic [ENTRY_W-1:0] read_value;
    wire logic [ENTRY_W-1:0] op_top_value;
    wire logic op_top_valid;
    wire logic [PTR_W-1:0] param_depth;
    wire logic [PTR_W-1:0] op_depth;
    wire logic [1:0] status;
    wire logic [APB_DW-1:0] prdata;
    wire logic pready;

    stack_cmd_t cmd_q[$];
    stack_reply_t reply_q[$];
    int idle_pct = 0;
    int errors = 0;

    logic [ENTRY_W-1:0] param_mem [STACK_DEPTH];
    logic [ENTRY_W-1:0] op_mem [STACK_DEPTH];
    logic [PTR_W-1:0] param_sp = '0;
    logic [PTR_W-1:0] op_sp = '0;
    logic [LIMIT_W-1:0] param_lim = LIMIT_RESET;
    logic [LIMIT_W-1:0] op_lim = LIMIT_RESET;

    dual_bounded_stack uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (cmd_action),
        .push_value   (cmd_push_value),
        .index        (cmd_index),
        .count        (cmd_count),
        .done         (done),
        .read_value   (read_value),
        .op_top_value (op_top_value),
        .op_top_valid (op_top_valid),
        .param_depth  (param_depth),
        .op_depth     (op_depth),
        .status       (status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // Deepest a stack may grow under a limit: the limit is capped at the store size,
    // and a stack of limit L holds L-1 entries; a limit of 0 allows none.
    function automatic int room_for(input logic [LIMIT_W-1:0] lim);
        int eff;
        eff = (int'(lim) > STACK_DEPTH) ? STACK_DEPTH : int'(lim);
        return (eff == 0) ? 0 : eff - 1;
    endfunction

    task automatic stacks_apply(input stack_cmd_t c);
        stack_reply_t r;
        r.read_value = '0;
        r.status = ST_OK;
        case (c.action)
            ACT_PUSH_PARAM:
            begin
                if (int'(param_sp) >= room_for(param_lim))
                begin
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    param_mem[param_sp[ADDR_W-1:0]] = c.push_value;
                    param_sp = param_sp + 1'b1;
                end
            end
            ACT_POP_PARAM:
            begin
                if (param_sp == '0)
                begin
                    r.status = ST_UNDERFLOW;
                end
                else
                begin
                    param_sp = param_sp - 1'b1;
                    r.read_value = param_mem[param_sp[ADDR_W-1:0]];
                end
            end
            ACT_READ_PARAM:
            begin
                if (PTR_W'(c.index) >= param_sp)
                begin
                    r.status = ST_BAD_INDEX;
                end
                else
                begin
                    r.read_value = param_mem[c.index];
                end
            end
            ACT_RELEASE_PARAM:
            begin
                if (c.count > param_sp)
                begin
                    r.status = ST_UNDERFLOW;
                end
                else
                begin
                    param_sp = param_sp - c.count;
                end
            end
            ACT_PUSH_OP:
            begin
                if (int'(op_sp) >= room_for(op_lim))
                begin
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    op_mem[op_sp[ADDR_W-1:0]] = c.push_value;
                    op_sp = op_sp + 1'b1;
                end
            end
            ACT_POP_OP:
            begin
                if (op_sp == '0)
                begin
                    r.status = ST_UNDERFLOW;
                end
                else
                begin
                    op_sp = op_sp - 1'b1;
                    r.read_value = op_mem[op_sp[ADDR_W-1:0]];
                end
            end
            default:
            begin
            end
        endcase
        r.op_top_valid = (op_sp != '0);
        r.op_top_value = r.op_top_valid ? op_mem[ADDR_W'(op_sp - 1'b1)] : '0;
        r.param_depth = param_sp;
        r.op_depth = op_sp;
        reply_q.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    function automatic stack_cmd_t mk_cmd(input logic [2:0] act, input logic [ENTRY_W-1:0] v,
                                          input logic [INDEX_W-1:0] idx,
                                          input logic [COUNT_W-1:0] cnt);
        stack_cmd_t c;
        c.action = act;
        c.push_value = v;
        c.index = idx;
        c.count = cnt;
        return c;
    endfunction

    function automatic stack_cmd_t random_cmd();
        stack_cmd_t c;
        int pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
        begin
            c.push_value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        else
        begin
            c.push_value = $urandom();
        end
        c.index = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom()) : INDEX_W'($urandom_range(0, 15));
        c.count = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom()) : COUNT_W'($urandom_range(0, 4));
        if (pick < 28)
        begin
            c.action = ACT_PUSH_PARAM;
        end
        else if (pick < 42)
        begin
            c.action = ACT_POP_PARAM;
        end
        else if (pick < 58)
        begin
            c.action = ACT_READ_PARAM;
        end
        else if (pick < 66)
        begin
            c.action = ACT_RELEASE_PARAM;
        end
        else if (pick < 82)
        begin
            c.action = ACT_PUSH_OP;
        end
        else if (pick < 95)
        begin
            c.action = ACT_POP_OP;
        end
        else
        begin
            c.action = 3'($urandom_range(6, 7));
        end
        return c;
    endfunction

    task automatic apb_write(input reg_idx_t r, input logic [LIMIT_W-1:0] v);
        logic [31:0] noise;
        noise = $urandom();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(4 * int'(r));
        pwdata <= {noise[APB_DW-1:LIMIT_W], v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (r == REG_PARAM_LIMIT)
        begin
            param_lim = v;
        end
        else
        begin
            op_lim = v;
        end
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (cmd_q.size() != 0 || start || reply_q.size() != 0);
    endtask

    // Command driver: a transfer completes at an edge with start high and busy low.
    always @(posedge clk)
    begin : driver
        stack_cmd_t nxt;
        stack_cmd_t cur;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                cur = mk_cmd(cmd_action, cmd_push_value, cmd_index, cmd_count);
                stacks_apply(cur);
            end
            if (!start || !busy)
            begin
                if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    nxt = cmd_q.pop_front();
                    start <= 1'b1;
                    cmd_action <= nxt.action;
                    cmd_push_value <= nxt.push_value;
                    cmd_index <= nxt.index;
                    cmd_count <= nxt.count;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        stack_reply_t want;
        if (rst_n && done)
        begin
            if (reply_q.size() == 0)
            begin
                errors++;
                $error("result strobe with no transfer outstanding");
            end
            else
            begin
                want = reply_q.pop_front();
                check_field("read_value", want.read_value, read_value);
                check_field("op_top_value", want.op_top_value, op_top_value);
                check_field("op_top_valid", 32'(want.op_top_valid), 32'(op_top_valid));
                check_field("param_depth", 32'(want.param_depth), 32'(param_depth));
                check_field("op_depth", 32'(want.op_depth), 32'(op_depth));
                check_field("status", 32'(want.status), 32'(status));
            end
        end
    end

    initial
    begin : stimulus
        int n;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 19;
        apb_write(REG_PARAM_LIMIT, 9'd256);
        apb_write(REG_OP_LIMIT, 9'd2);
        cmd_q.push_back(mk_cmd(ACT_POP_PARAM, 32'h0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_POP_OP, 32'hFFFF_FFFF, 8'd255, 9'd511));
        cmd_q.push_back(mk_cmd(ACT_READ_PARAM, 32'h0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_RELEASE_PARAM, 32'h0, 8'd0, 9'd1));
        cmd_q.push_back(mk_cmd(ACT_RELEASE_PARAM, 32'h0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_PUSH_PARAM, 32'h0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_PUSH_PARAM, 32'hFFFF_FFFF, 8'd255, 9'd511));
        cmd_q.push_back(mk_cmd(ACT_READ_PARAM, 32'h0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_READ_PARAM, 32'h0, 8'd1, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_READ_PARAM, 32'h0, 8'd2, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_READ_PARAM, 32'h0, 8'd255, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_PUSH_OP, 32'hA5A5_A5A5, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_PUSH_OP, 32'h5A5A_5A5A, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_POP_OP, 32'h0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_POP_OP, 32'h0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(3'd6, 32'h1234_5678, 8'd3, 9'd3));
        cmd_q.push_back(mk_cmd(3'd7, 32'hFFFF_FFFF, 8'd255, 9'd511));
        cmd_q.push_back(mk_cmd(ACT_RELEASE_PARAM, 32'h0, 8'd0, 9'd511));
        cmd_q.push_back(mk_cmd(ACT_RELEASE_PARAM, 32'h0, 8'd0, 9'd2));
        cmd_q.push_back(mk_cmd(ACT_PUSH_PARAM, 32'h1234_5678, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_POP_PARAM, 32'h0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_POP_PARAM, 32'h0, 8'd0, 9'd0));
        cmd_q.push_back(mk_cmd(ACT_PUSH_OP, 32'hFFFF_FFFF, 8'd0, 9'd0));
        repeat (100) cmd_q.push_back(random_cmd());
        wait_idle();

        apb_write(REG_PARAM_LIMIT, 9'd0);
        apb_write(REG_OP_LIMIT, 9'd511);
        repeat (70) cmd_q.push_back(random_cmd());
        wait_idle();

        idle_pct = 72;
        apb_write(REG_PARAM_LIMIT, 9'd9);
        apb_write(REG_OP_LIMIT, 9'd1);
        repeat (90) cmd_q.push_back(random_cmd());
        wait_idle();

        // Fill both stacks past their capacity, reading back entries on the way up.
        apb_write(REG_PARAM_LIMIT, 9'd511);
        apb_write(REG_OP_LIMIT, 9'd257);
        for (n = 0; n < 262; n++)
        begin
            cmd_q.push_back(mk_cmd(ACT_PUSH_PARAM, $urandom(), INDEX_W'($urandom()),
                                   COUNT_W'($urandom())));
            if ($urandom_range(0, 3) == 0)
            begin
                cmd_q.push_back(mk_cmd(ACT_READ_PARAM, $urandom(),
                                       INDEX_W'($urandom_range(0, n + 1)), COUNT_W'($urandom())));
            end
        end
        for (n = 0; n < 260; n++)
        begin
            cmd_q.push_back(mk_cmd(ACT_PUSH_OP, $urandom(), INDEX_W'($urandom()),
                                   COUNT_W'($urandom())));
        end
        repeat (30) cmd_q.push_back(random_cmd());
        wait_idle();

        // Limits now sit far below the depths reached above.
        idle_pct = 0;
        apb_write(REG_PARAM_LIMIT, 9'd16);
        apb_write(REG_OP_LIMIT, 9'd5);
        repeat (80) cmd_q.push_back(random_cmd());
        wait_idle();

        repeat (8) @(posedge clk);
        if (errors == 0 && reply_q.size() == 0)
        begin
            $display("[dual_bounded_stack] OK");
        end
        else
        begin
            $display("[dual_bounded_stack] ERROR");
        end
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("[dual_bounded_stack] ERROR");
        $finish;
    end

endmodule

>>> dual_bounded_stack.f
src/dbs_pkg.sv
src/dbs_cfg.sv
src/dbs_param_stack.sv
src/dbs_op_stack.sv
src/dual_bounded_stack.sv
tb/sv/dual_bounded_stack_test.sv
